### sv/slq_pkg.sv
// Shared constants and types of the sorted-list timer queue.
`default_nettype none
package slq_pkg;
   localparam int CAPACITY = 64;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int LINK_W   = SLOT_W + 1;
   localparam int KEY_W    = 32;
   localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(CAPACITY);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_EXPIRE = 2'd2;

   localparam logic [2:0] STS_OK      = 3'd0;
   localparam logic [2:0] STS_BUSY    = 3'd1;
   localparam logic [2:0] STS_EMPTY   = 3'd2;
   localparam logic [2:0] STS_EXPIRED = 3'd3;
   localparam logic [2:0] STS_NONE    = 3'd4;

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic [SLOT_W-1:0] wr_addr;
      logic              wr_key_en;
      logic              wr_up_en;
      logic              wr_dn_en;
      logic [KEY_W-1:0]  wr_key;
      logic [LINK_W-1:0] wr_up;
      logic [LINK_W-1:0] wr_dn;
   } mem_req_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [LINK_W-1:0] up;
      logic [LINK_W-1:0] dn;
   } mem_rd_type;
endpackage
`default_nettype wire

### sv/slq_node_ram.sv
// Node memory: key and both links of every slot, one read and one write port.
`default_nettype none
module slq_node_ram
   import slq_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_req_type req,
   output mem_rd_type       rd_data
);
   logic [KEY_W-1:0]  key_mem [CAPACITY];
   logic [LINK_W-1:0] up_mem  [CAPACITY];
   logic [LINK_W-1:0] dn_mem  [CAPACITY];
   mem_rd_type        rd_ff;

   always_ff @(posedge clock) begin
      if (req.wr_key_en) key_mem[req.wr_addr] <= req.wr_key;
      if (req.wr_up_en)  up_mem[req.wr_addr]  <= req.wr_up;
      if (req.wr_dn_en)  dn_mem[req.wr_addr]  <= req.wr_dn;
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_ff.key <= key_mem[req.rd_addr];
         rd_ff.up  <= up_mem[req.rd_addr];
         rd_ff.dn  <= dn_mem[req.rd_addr];
      end
   end

   assign rd_data = rd_ff;
endmodule
`default_nettype wire

### sv/sorted_list_timer_queue_core.sv
// Top level: command sequencer of the sorted-list timer queue.
// Priority queue of 64 slots kept as a doubly linked list in a node memory,
// sorted from highest key (head) to lowest (tail). An item is taken when
// start is high and busy low; busy holds off the next item until the command
// is done. The node memory read is registered, so insert walks down from the
// head one link per cycle. Insert into an empty list writes the entry at once.
// Any other insert walks to its place, writes the new entry, then relinks the
// entry where the walk stopped and, when it lands between two entries, the one above.
// Delete reads the entry and relinks its upper neighbor, then its lower
// neighbor if it has one. Expire removes due entries from the tail and
// answers at once on an empty list; busy and empty-slot errors do too. Each
// result is registered and stays for one cycle with rsp_strobe; the
// receiver cannot stall it. Command code 3 is dropped with no result.
`default_nettype none
module sorted_list_timer_queue_core
   import slq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_cmd,
   input  wire logic [SLOT_W-1:0]        req_slot,
   input  wire logic signed [KEY_W-1:0]  req_priority_req,
   input  wire logic signed [KEY_W-1:0]  req_now_time,
   output logic                          rsp_strobe,
   output logic [2:0]                    rsp_status,
   output logic [SLOT_W-1:0]             rsp_out_slot,
   output logic signed [KEY_W-1:0]       rsp_out_priority,
   output logic                          rsp_last
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_INS_CHK, ST_INS_W2, ST_INS_W3, ST_DEL_CHK, ST_DEL_W2,
      ST_EXP_CHK, ST_EXP_FIN
   } state_type;

   typedef struct packed {
      logic              strobe;
      logic [2:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  prio;
      logic              last;
   } rsp_type;

   function automatic rsp_type mk_rsp(logic [2:0] st, logic [SLOT_W-1:0] sl,
                                      logic [KEY_W-1:0] pr, logic lst);
      rsp_type r;
      r.strobe = 1'b1;
      r.status = st;
      r.slot   = sl;
      r.prio   = pr;
      r.last   = lst;
      return r;
   endfunction

   state_type         state_ff, state_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [LINK_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [LINK_W-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              w2_up_ff, w2_up_in, w3_en_ff, w3_en_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   logic [KEY_W-1:0]  pend_key_ff, pend_key_in;
   rsp_type           rsp_ff, rsp_in;
   mem_req_type       mreq;
   mem_rd_type        mrd;
   logic              due;

   slq_node_ram u_ram (
      .clock   (clock),
      .req     (mreq),
      .rd_data (mrd)
   );

   assign due = $signed(mrd.key) <= $signed(key_ff);

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      slot_in      = slot_ff;
      key_in       = key_ff;
      w2_up_in     = w2_up_ff;
      w3_en_in     = w3_en_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      pend_key_in  = pend_key_ff;
      rsp_in       = '0;
      mreq         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               slot_in = req_slot;
               case (req_cmd)
                  CMD_INSERT: begin
                     key_in = req_priority_req;
                     if (valid_ff[req_slot]) begin
                        rsp_in = mk_rsp(STS_BUSY, req_slot, '0, 1'b1);
                     end else if (head_ff == NONE_LINK) begin
                        mreq.wr_addr   = req_slot;
                        mreq.wr_key_en = 1'b1;
                        mreq.wr_up_en  = 1'b1;
                        mreq.wr_dn_en  = 1'b1;
                        mreq.wr_key    = req_priority_req;
                        mreq.wr_up     = NONE_LINK;
                        mreq.wr_dn     = NONE_LINK;
                        head_in = {1'b0, req_slot};
                        tail_in = {1'b0, req_slot};
                        valid_in[req_slot] = 1'b1;
                        rsp_in = mk_rsp(STS_OK, req_slot, '0, 1'b1);
                     end else begin
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = head_ff[SLOT_W-1:0];
                        cur_in   = head_ff;
                        prev_in  = NONE_LINK;
                        state_in = ST_INS_CHK;
                     end
                  end
                  CMD_DELETE: begin
                     if (!valid_ff[req_slot]) begin
                        rsp_in = mk_rsp(STS_EMPTY, req_slot, '0, 1'b1);
                     end else begin
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = req_slot;
                        state_in = ST_DEL_CHK;
                     end
                  end
                  CMD_EXPIRE: begin
                     key_in = req_now_time;
                     if (tail_ff == NONE_LINK) begin
                        rsp_in = mk_rsp(STS_NONE, '0, '0, 1'b1);
                     end else begin
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = tail_ff[SLOT_W-1:0];
                        cur_in   = tail_ff;
                        pend_in  = 1'b0;
                        state_in = ST_EXP_CHK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INS_CHK: begin
            if (due || mrd.dn == NONE_LINK) begin
               mreq.wr_addr   = slot_ff;
               mreq.wr_key_en = 1'b1;
               mreq.wr_up_en  = 1'b1;
               mreq.wr_dn_en  = 1'b1;
               mreq.wr_key    = key_ff;
               valid_in[slot_ff] = 1'b1;
               rsp_in   = mk_rsp(STS_OK, slot_ff, '0, 1'b1);
               state_in = ST_INS_W2;
               if (due) begin
                  // place above cur, below prev
                  mreq.wr_up = prev_ff;
                  mreq.wr_dn = cur_ff;
                  w2_up_in   = 1'b1;
                  w3_en_in   = prev_ff != NONE_LINK;
                  if (prev_ff == NONE_LINK) head_in = {1'b0, slot_ff};
               end else begin
                  // append at the tail
                  mreq.wr_up = cur_ff;
                  mreq.wr_dn = NONE_LINK;
                  w2_up_in   = 1'b0;
                  w3_en_in   = 1'b0;
                  tail_in    = {1'b0, slot_ff};
               end
            end else begin
               mreq.rd_en   = 1'b1;
               mreq.rd_addr = mrd.dn[SLOT_W-1:0];
               prev_in = cur_ff;
               cur_in  = mrd.dn;
            end
         end
         ST_INS_W2: begin
            mreq.wr_addr  = cur_ff[SLOT_W-1:0];
            mreq.wr_up_en = w2_up_ff;
            mreq.wr_dn_en = !w2_up_ff;
            mreq.wr_up    = {1'b0, slot_ff};
            mreq.wr_dn    = {1'b0, slot_ff};
            state_in = w3_en_ff ? ST_INS_W3 : ST_IDLE;
         end
         ST_INS_W3: begin
            mreq.wr_addr  = prev_ff[SLOT_W-1:0];
            mreq.wr_dn_en = 1'b1;
            mreq.wr_dn    = {1'b0, slot_ff};
            state_in = ST_IDLE;
         end
         ST_DEL_CHK: begin
            valid_in[slot_ff] = 1'b0;
            rsp_in = mk_rsp(STS_OK, slot_ff, '0, 1'b1);
            if (mrd.up != NONE_LINK) begin
               mreq.wr_addr  = mrd.up[SLOT_W-1:0];
               mreq.wr_dn_en = 1'b1;
               mreq.wr_dn    = mrd.dn;
            end else begin
               head_in = mrd.dn;
            end
            if (mrd.dn == NONE_LINK) begin
               tail_in  = mrd.up;
               state_in = ST_IDLE;
            end else begin
               cur_in   = mrd.dn;
               prev_in  = mrd.up;
               state_in = ST_DEL_W2;
            end
         end
         ST_DEL_W2: begin
            mreq.wr_addr  = cur_ff[SLOT_W-1:0];
            mreq.wr_up_en = 1'b1;
            mreq.wr_up    = prev_ff;
            state_in = ST_IDLE;
         end
         ST_EXP_CHK: begin
            if (due) begin
               // flush the previous entry, hold this one until its last flag is known
               if (pend_ff) rsp_in = mk_rsp(STS_EXPIRED, pend_slot_ff, pend_key_ff, 1'b0);
               pend_in      = 1'b1;
               pend_slot_in = cur_ff[SLOT_W-1:0];
               pend_key_in  = mrd.key;
               valid_in[cur_ff[SLOT_W-1:0]] = 1'b0;
               tail_in = mrd.up;
               if (mrd.up == NONE_LINK) begin
                  head_in  = NONE_LINK;
                  state_in = ST_EXP_FIN;
               end else begin
                  mreq.wr_addr  = mrd.up[SLOT_W-1:0];
                  mreq.wr_dn_en = 1'b1;
                  mreq.wr_dn    = NONE_LINK;
                  mreq.rd_en    = 1'b1;
                  mreq.rd_addr  = mrd.up[SLOT_W-1:0];
                  cur_in = mrd.up;
               end
            end else begin
               if (pend_ff) rsp_in = mk_rsp(STS_EXPIRED, pend_slot_ff, pend_key_ff, 1'b1);
               else         rsp_in = mk_rsp(STS_NONE, '0, '0, 1'b1);
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_EXP_FIN: begin
            rsp_in   = mk_rsp(STS_EXPIRED, pend_slot_ff, pend_key_ff, 1'b1);
            pend_in  = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         head_ff  <= NONE_LINK;
         tail_ff  <= NONE_LINK;
         pend_ff  <= 1'b0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         pend_ff  <= pend_in;
         rsp_ff   <= rsp_in;
      end
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      slot_ff      <= slot_in;
      key_ff       <= key_in;
      w2_up_ff     <= w2_up_in;
      w3_en_ff     <= w3_en_in;
      pend_slot_ff <= pend_slot_in;
      pend_key_ff  <= pend_key_in;
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_strobe       = rsp_ff.strobe;
   assign rsp_status       = rsp_ff.status;
   assign rsp_out_slot     = rsp_ff.slot;
   assign rsp_out_priority = rsp_ff.prio;
   assign rsp_last         = rsp_ff.last;

`ifndef SYNTHESIS
   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      (head_ff == NONE_LINK) == (tail_ff == NONE_LINK))
      else $error("head and tail disagree on empty list");
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !pend_ff)
      else $error("expired entry left pending while idle");
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != STS_EXPIRED |-> rsp_last)
      else $error("non-expire result without last flag");
   a_empty_list: assert property (@(posedge clock) disable iff (reset)
      valid_ff == '0 && !busy |-> head_ff == NONE_LINK)
      else $error("list head set with no valid slot");
`endif
endmodule
`default_nettype wire

### test/tb_sorted_list_timer_queue_core.sv
// Self-checking testbench of the sorted-list timer queue core.
`default_nettype none
module tb_sorted_list_timer_queue_core;
   import slq_pkg::*;

   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic [2:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  prio;
      logic              last;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_cmd = CMD_INSERT;
   logic [SLOT_W-1:0] req_slot = '0;
   logic signed [KEY_W-1:0] req_priority_req = '0;
   logic signed [KEY_W-1:0] req_now_time = '0;
   logic rsp_strobe;
   logic [2:0] rsp_status;
   logic [SLOT_W-1:0] rsp_out_slot;
   logic signed [KEY_W-1:0] rsp_out_priority;
   logic rsp_last;

   sorted_list_timer_queue_core uut (.*);

   // Shadow of the list; head is highest key.
   logic signed [KEY_W-1:0] key_q [CAPACITY];
   int unsigned up_q [CAPACITY];
   int unsigned dn_q [CAPACITY];
   bit valid_q [CAPACITY];
   int unsigned head_q = CAPACITY, tail_q = CAPACITY;
   rsp_item_type expected_rsps[$];
   int errors = 0;
   bit no_gaps = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #20000000;
      $display("Mismatches found");
      $finish;
   end

   function automatic void unlink_entry(int unsigned s);
      int unsigned u, d;
      u = up_q[s];
      d = dn_q[s];
      if (u < CAPACITY) dn_q[u] = d;
      else head_q = d;
      if (d < CAPACITY) up_q[d] = u;
      else tail_q = u;
      valid_q[s] = 0;
   endfunction

   function automatic void link_entry(int unsigned s, logic signed [KEY_W-1:0] k);
      int unsigned cur, nxt;
      key_q[s] = k;
      valid_q[s] = 1;
      if (head_q >= CAPACITY) begin
         head_q = s; tail_q = s; up_q[s] = CAPACITY; dn_q[s] = CAPACITY;
         return;
      end
      if (key_q[head_q] <= k) begin
         up_q[s] = CAPACITY; dn_q[s] = head_q; up_q[head_q] = s; head_q = s;
         return;
      end
      cur = head_q;
      forever begin
         nxt = dn_q[cur];
         if (nxt >= CAPACITY) break;
         if (key_q[nxt] <= k) begin
            dn_q[cur] = s; up_q[s] = cur; dn_q[s] = nxt; up_q[nxt] = s;
            return;
         end
         cur = nxt;
      end
      dn_q[cur] = s; up_q[s] = cur; dn_q[s] = CAPACITY; tail_q = s;
   endfunction

   function automatic void predict_queue(logic [1:0] cmd, logic [SLOT_W-1:0] s,
                                         logic signed [KEY_W-1:0] k,
                                         logic signed [KEY_W-1:0] t);
      int n;
      n = 0;
      case (cmd)
         CMD_INSERT: begin
            if (valid_q[s]) expected_rsps.push_back({STS_BUSY, s, 32'd0, 1'b1});
            else begin
               link_entry(int'(s), k);
               expected_rsps.push_back({STS_OK, s, 32'd0, 1'b1});
            end
         end
         CMD_DELETE: begin
            if (!valid_q[s]) expected_rsps.push_back({STS_EMPTY, s, 32'd0, 1'b1});
            else begin
               unlink_entry(int'(s));
               expected_rsps.push_back({STS_OK, s, 32'd0, 1'b1});
            end
         end
         CMD_EXPIRE: begin
            while (tail_q < CAPACITY && key_q[tail_q] <= t) begin
               expected_rsps.push_back({STS_EXPIRED, SLOT_W'(tail_q), key_q[tail_q], 1'b0});
               unlink_entry(tail_q);
               n++;
            end
            if (n == 0) expected_rsps.push_back({STS_NONE, {SLOT_W{1'b0}}, 32'd0, 1'b1});
            else expected_rsps[$].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // Check every strobed result against the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type want, got;
      if (!reset && rsp_strobe) begin
         got = {rsp_status, rsp_out_slot, rsp_out_priority, rsp_last};
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (want.status !== got.status)
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            if (want.slot !== got.slot)
               $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
            if (want.prio !== got.prio)
               $display("%0t: priority expected %0d actual %0d", $time,
                        $signed(want.prio), $signed(got.prio));
            if (want.last !== got.last)
               $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            if (want !== got) errors++;
         end
      end
   end

   task automatic send_item(logic [1:0] cmd, logic [SLOT_W-1:0] s,
                            logic signed [KEY_W-1:0] k, logic signed [KEY_W-1:0] t);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      repeat (gap) @(negedge clock);
      req_cmd = cmd; req_slot = s; req_priority_req = k; req_now_time = t;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_queue(cmd, s, k, t);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic drain_queue();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic logic signed [KEY_W-1:0] rand_key();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'sh7fffffff - $urandom_range(0, 2);
         2: return 32'sh80000000 + $urandom_range(0, 2);
         default: return $urandom_range(0, 40) - 20;
      endcase
   endfunction

   task automatic test_directed();
      send_item(CMD_EXPIRE, 0, 0, 32'sh7fffffff);           // empty queue expires nothing
      send_item(CMD_DELETE, 63, 0, 0);                       // delete empty slot
      send_item(CMD_INSERT, 0, 32'sh7fffffff, 0);
      send_item(CMD_INSERT, 63, 32'sh80000000, 0);
      send_item(CMD_INSERT, 63, 5, 0);                       // occupied slot
      send_item(CMD_INSERT, 5, 10, 0);
      send_item(CMD_INSERT, 6, 10, 0);                       // equal keys, newest nearer the head
      send_item(CMD_INSERT, 7, -32'sd3, 0);                  // insert just above the tail
      send_item(CMD_INSERT, 8, 32'sh7fffffff, 0);            // new head
      send_item(CMD_SPARE, 9, 0, 0);                         // unused command
      send_item(CMD_DELETE, 5, 0, 0);
      send_item(CMD_DELETE, 0, 0, 0);
      send_item(CMD_EXPIRE, 0, 0, 32'sh80000000);
      send_item(CMD_EXPIRE, 0, 0, 10);
      send_item(CMD_EXPIRE, 0, 0, 32'sh7fffffff);
      drain_queue();
   endtask

   task automatic test_fill_and_flush();
      no_gaps = 1;
      for (int i = 0; i < CAPACITY; i++) send_item(CMD_INSERT, SLOT_W'(i), rand_key(), 0);
      no_gaps = 0;
      send_item(CMD_EXPIRE, 0, 0, 32'sh7fffffff);            // full table drains at once
      drain_queue();
   endtask

   task automatic test_random(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50)
            send_item(CMD_INSERT, SLOT_W'($urandom), rand_key(), KEY_W'($urandom));
         else if (r < 75)
            send_item(CMD_DELETE, SLOT_W'($urandom), KEY_W'($urandom), KEY_W'($urandom));
         else if (r < 97)
            send_item(CMD_EXPIRE, SLOT_W'($urandom), KEY_W'($urandom), rand_key());
         else
            send_item(CMD_SPARE, SLOT_W'($urandom), KEY_W'($urandom), KEY_W'($urandom));
         if (i == count / 2) drain_queue();                 // let every result arrive
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_fill_and_flush();
      test_random(280);
      drain_queue();
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire
